>>> design/assert_macros.svh
// Assertion macros shared by the RTL. The checking forms are used in
// simulation; synthesis defines SYNTH and gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// The expression holds at every clock edge outside reset.
`define CHECK_NOW(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
// When the antecedent holds, the consequent holds in the next cycle.
`define CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CHECK_NOW(lbl, expr)
`define CHECK_NEXT(lbl, ante, cons)
`endif
`endif

>>> design/lsbbuf_pkg.sv
package lsbbuf_pkg;

  localparam int CAP_BITS  = 4096;
  localparam int LEN_W     = 13;
  localparam int IDX_W     = 12;
  localparam int ADDR_W    = 9;
  localparam int STORE_BYTES = CAP_BITS / 8;
  localparam int WORD_BITS = 32;
  localparam int CNT_W     = 7;
  localparam int RUN_BYTES = 5;

  localparam logic [2:0] MODE_APPEND = 3'd0;
  localparam logic [2:0] MODE_READ   = 3'd1;
  localparam logic [2:0] MODE_SET    = 3'd2;
  localparam logic [2:0] MODE_TOGGLE = 3'd3;
  localparam logic [2:0] MODE_CLEAR  = 3'd4;

  typedef struct packed {
    logic [2:0]       mode;
    logic [31:0]      value;
    logic [CNT_W-1:0] bit_count;
    logic [IDX_W-1:0] bit_index;
  } item_t;

  typedef struct packed {
    logic [31:0]      read_data;
    logic [CNT_W-1:0] bits_done;
    logic             ok;
    logic [LEN_W-1:0] length;
  } result_t;

  typedef struct packed {
    logic load;
    logic fetch;
    logic app_wr;
    logic bit_wr;
    logic run;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_append;
    logic ok;
    logic has_bytes;
    logic cnt_last;
  } ctl_status_t;

endpackage

>>> design/lsbbuf_datapath.sv
module lsbbuf_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  lsbbuf_pkg::ctl_cmd_t  cmd,
  input  lsbbuf_pkg::item_t     item,
  output lsbbuf_pkg::ctl_status_t status,
  output lsbbuf_pkg::result_t   result
);
  import lsbbuf_pkg::*;
  `include "assert_macros.svh"

  logic [7:0]        mem [STORE_BYTES];
  logic [7:0]        rdata;
  logic [LEN_W-1:0]  len;
  logic [2:0]        mode_q;
  logic [2:0]        off_q;
  logic [ADDR_W-1:0] ptr;
  logic [3:0]        cnt;
  logic [71:0]       wbuf;
  logic [39:0]       acc;
  logic [CNT_W-1:0]  done_q;
  logic              ok_q;
  logic              bitval_q;
  logic              first_q;
  logic              run_q;

  // Decode of the incoming item, used only on load.
  logic [5:0]        pad;
  logic [63:0]       stream;
  logic [LEN_W-1:0]  space;
  logic [CNT_W-1:0]  app_n;
  logic [7:0]        app_sum;
  logic [3:0]        app_nb;
  logic              idx_ok;
  logic [LEN_W-1:0]  avail;
  logic [CNT_W-1:0]  rd_n;
  logic [CNT_W-1:0]  rd_done;

  // Per-mode values taken into the working registers on load.
  logic [2:0]        ld_off;
  logic [ADDR_W-1:0] ld_ptr;
  logic [CNT_W-1:0]  ld_done;
  logic              ld_ok;
  logic [3:0]        ld_cnt;

  logic              mem_we;
  logic              mem_re;
  logic [7:0]        lowmask;
  logic [7:0]        wbyte;
  logic [7:0]        bit_byte;
  logic [39:0]       shifted;
  logic [32:0]       rmask;
  result_t           res_next;

  always_comb begin
    pad     = (item.bit_count > CNT_W'(WORD_BITS)) ?
              6'(item.bit_count - CNT_W'(WORD_BITS)) : 6'd0;
    stream  = {32'd0, item.value} << pad;
    space   = LEN_W'(CAP_BITS) - len;
    if (LEN_W'(item.bit_count) < space) begin
      app_n = item.bit_count;
    end else begin
      app_n = space[CNT_W-1:0];
    end
    app_sum = {5'd0, len[2:0]} + {1'b0, app_n} + 8'd7;
    app_nb  = (app_n == '0) ? 4'd0 : app_sum[6:3];
    idx_ok  = {1'b0, item.bit_index} < len;
    avail   = len - {1'b0, item.bit_index};
    rd_n    = (item.bit_count > CNT_W'(WORD_BITS)) ? CNT_W'(WORD_BITS) : item.bit_count;
    if (!idx_ok) begin
      rd_done = '0;
    end else if (LEN_W'(rd_n) < avail) begin
      rd_done = rd_n;
    end else begin
      rd_done = avail[CNT_W-1:0];
    end
  end

  always_comb begin
    ld_off  = item.bit_index[2:0];
    ld_ptr  = item.bit_index[IDX_W-1:3];
    ld_done = '0;
    ld_ok   = 1'b0;
    ld_cnt  = '0;
    case (item.mode)
      MODE_APPEND: begin
        ld_off  = len[2:0];
        ld_ptr  = len[IDX_W-1:3];
        ld_done = app_n;
        ld_ok   = (app_n == item.bit_count);
        ld_cnt  = app_nb;
      end
      MODE_READ: begin
        ld_done = rd_done;
        ld_ok   = idx_ok;
        ld_cnt  = 4'(RUN_BYTES);
      end
      MODE_SET, MODE_TOGGLE: begin
        ld_ok = idx_ok;
      end
      MODE_CLEAR: begin
        ld_ok = 1'b1;
      end
      default: begin
        ld_ok = 1'b0;
      end
    endcase
  end

  assign mem_we = cmd.app_wr | cmd.bit_wr;
  assign mem_re = cmd.fetch | cmd.run;

  always_comb begin
    lowmask  = ~(8'hFF << off_q);
    bit_byte = rdata;
    bit_byte[off_q] = (mode_q == MODE_SET) ? bitval_q : ~rdata[off_q];
    if (cmd.bit_wr) begin
      wbyte = bit_byte;
    end else if (first_q) begin
      wbyte = (wbuf[7:0] & ~lowmask) | (rdata & lowmask);
    end else begin
      wbyte = wbuf[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ptr] <= wbyte;
    end
    if (mem_re) begin
      rdata <= mem[ptr];
    end
  end

  always_comb begin
    shifted = acc >> off_q;
    rmask   = ~(33'h1_FFFF_FFFF << done_q);
    res_next.read_data = (mode_q == MODE_READ) ? (shifted[31:0] & rmask[31:0]) : 32'd0;
    res_next.bits_done = done_q;
    res_next.ok        = ok_q;
    res_next.length    = len;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len   <= '0;
      run_q <= 1'b0;
    end else begin
      run_q <= cmd.run;
      if (cmd.load) begin
        case (item.mode)
          MODE_APPEND: begin
            len <= len + LEN_W'(app_n);
          end
          MODE_CLEAR: begin
            len <= '0;
          end
          default: begin
            len <= len;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q   <= item.mode;
      bitval_q <= item.value[0];
      first_q  <= 1'b1;
      wbuf     <= {8'd0, stream} << len[2:0];
      off_q    <= ld_off;
      ptr      <= ld_ptr;
      done_q   <= ld_done;
      ok_q     <= ld_ok;
      cnt      <= ld_cnt;
    end else begin
      if (cmd.app_wr) begin
        wbuf    <= wbuf >> 8;
        first_q <= 1'b0;
      end
      if (cmd.app_wr || cmd.run) begin
        ptr <= ptr + ADDR_W'(1);
        cnt <= cnt - 4'd1;
      end
    end
    if (run_q) begin
      acc <= {rdata, acc[39:8]};
    end
    if (cmd.finish) begin
      result <= res_next;
    end
  end

  assign status.is_append = (mode_q == MODE_APPEND);
  assign status.ok        = ok_q;
  assign status.has_bytes = (cnt != 4'd0);
  assign status.cnt_last  = (cnt == 4'd1);

  `CHECK_NOW(a_len_in_range, len <= LEN_W'(CAP_BITS))
  `CHECK_NOW(a_no_rw_clash, !(mem_we && mem_re))
  `CHECK_NOW(a_write_has_bytes, !cmd.app_wr || (cnt != 4'd0))
endmodule

>>> design/lsbbuf_ctrl.sv
module lsbbuf_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [2:0]              mode,
  input  lsbbuf_pkg::ctl_status_t status,
  output lsbbuf_pkg::ctl_cmd_t    cmd,
  output logic                    busy,
  output logic                    done
);
  import lsbbuf_pkg::*;
  `include "assert_macros.svh"

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_APP   = 3'd2;
  localparam logic [2:0] S_BIT   = 3'd3;
  localparam logic [2:0] S_RUN   = 3'd4;
  localparam logic [2:0] S_TAIL  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (mode inside {MODE_APPEND, MODE_SET, MODE_TOGGLE}) begin
            state_next = S_FETCH;
          end else if (mode == MODE_READ) begin
            state_next = S_RUN;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        if (status.is_append) begin
          state_next = status.has_bytes ? S_APP : S_FIN;
        end else begin
          state_next = status.ok ? S_BIT : S_FIN;
        end
      end
      S_APP: begin
        cmd.app_wr = 1'b1;
        if (status.cnt_last) begin
          state_next = S_FIN;
        end
      end
      S_BIT: begin
        cmd.bit_wr = 1'b1;
        state_next = S_FIN;
      end
      S_RUN: begin
        cmd.run = 1'b1;
        if (status.cnt_last) begin
          state_next = S_TAIL;
        end
      end
      S_TAIL: begin
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_FIN);
    end
  end

  assign busy = (state != S_IDLE);

  `CHECK_NEXT(a_fin_strobes, state == S_FIN, done)
  `CHECK_NOW(a_done_in_idle, !done || (state == S_IDLE))
  `CHECK_NEXT(a_start_leaves_idle, start && (state == S_IDLE), state != S_IDLE)
endmodule

>>> design/lsb_first_bit_buffer.sv
// LSB-first bit buffer: a 4096-bit store with a length counter. Bit i of the
// sequence lives in byte i/8 of a byte-wide memory at bit position i%8.
// A command is transferred at a rising edge where start is high and busy is
// low; its fields (mode, value, bit_count, bit_index) travel in item. Every
// command produces exactly one result, which appears on result while done is
// high for a single cycle and stays there until the next result. The receiver
// cannot hold results off, and the block never needs it to: a new command may
// be transferred in the same cycle in which the previous result is on the
// ports. The steps of each command, set by a single memory port (one byte per
// cycle), are:
//   append:        one read of the partial first byte, one write per byte
//                  touched, the result register, the done cycle.
//   read run:      five byte reads, one capture, the result register, the
//                  done cycle.
//   set or toggle: read, write, result, done; no write if the index is bad.
//   clear, unused modes: result and done only.
// Reset clears the length and the controller. The memory is not cleared:
// bits at or above the length are never returned before an append has
// written them.
module lsb_first_bit_buffer (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  lsbbuf_pkg::item_t   item,
  output logic                done,
  output lsbbuf_pkg::result_t result
);
  import lsbbuf_pkg::*;

  ctl_cmd_t    cmd;
  ctl_status_t status;

  // The controller sequences memory accesses; the datapath owns the store,
  // the length register and the result register.
  lsbbuf_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .mode   (item.mode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  lsbbuf_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .item   (item),
    .status (status),
    .result (result)
  );
endmodule
